>>> hdl/cle_pkg.sv
`default_nettype none

package cle_pkg;

  localparam logic [7:0] MaxLenReset = 8'd127;

  // escape tracking
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // special input bytes
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CSI_LO   = 8'h40;
  localparam logic [7:0] CSI_HI   = 8'h7e;

  localparam int MaxBeats = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] line_length;
  } result_t;

  // beats caused by one input byte; cnt of zero means nothing to send
  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MaxBeats-1:0]     res;
  } burst_t;

endpackage

`default_nettype wire

>>> hdl/cle_decode.sv
`default_nettype none

module cle_decode
  import cle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output burst_t          burst
);

  logic [7:0] max_len_r;
  logic [7:0] cursor_r, cursor_nxt;
  logic [1:0] mode_r, mode_nxt;

  logic [7:0] lim;
  logic [7:0] cur_inc;
  result_t    echo_res;

  always_comb begin
    lim     = (max_len_r == 8'd0) ? 8'd1 : max_len_r;
    cur_inc = (cursor_r == 8'hff) ? 8'hff : cursor_r + 8'd1;

    echo_res = '0;
    echo_res.kind       = KIND_ECHO;
    echo_res.echo_valid = 1'b1;

    burst      = '0;
    cursor_nxt = cursor_r;
    mode_nxt   = mode_r;

    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = (rx_byte == CH_LBRK) ? MODE_CSI : MODE_NORMAL;
      end
      MODE_CSI: begin
        if (rx_byte >= CSI_LO && rx_byte <= CSI_HI) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        unique case (rx_byte)
          CH_ETX, CH_EOT: begin
            burst.cnt         = 2'd1;
            burst.res[0].kind = KIND_ABORT;
            cursor_nxt        = 8'd0;
          end
          CH_BS: begin
            if (cursor_r != 8'd0) begin
              burst.cnt              = 2'd1;
              burst.res[0]           = echo_res;
              burst.res[0].echo_byte = CH_BS;
              cursor_nxt             = cursor_r - 8'd1;
            end
          end
          CH_LF: begin
            burst.cnt              = 2'd1;
            burst.res[0]           = echo_res;
            burst.res[0].echo_byte = CH_LF;
          end
          CH_CR: begin
            burst.cnt                = 2'd3;
            burst.res[0]             = echo_res;
            burst.res[0].echo_byte   = CH_LF;
            burst.res[1]             = echo_res;
            burst.res[1].echo_byte   = CH_CR;
            burst.res[2].kind        = KIND_DONE;
            burst.res[2].line_length = cursor_r;
            cursor_nxt               = 8'd0;
          end
          CH_ESC: begin
            mode_nxt = MODE_ESC;
          end
          default: begin
            burst.res[0].kind        = KIND_ECHO;
            burst.res[0].echo_valid  = (rx_byte != 8'd0);
            burst.res[0].echo_byte   = rx_byte;
            burst.res[0].store_valid = 1'b1;
            burst.res[0].store_index = cursor_r;
            if (cur_inc >= lim) begin
              burst.cnt                = 2'd2;
              burst.res[1].kind        = KIND_DONE;
              burst.res[1].line_length = cur_inc;
              cursor_nxt               = 8'd0;
            end else begin
              burst.cnt  = 2'd1;
              cursor_nxt = cur_inc;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
      cursor_r  <= 8'd0;
      mode_r    <= MODE_NORMAL;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_data;
      end
      if (take) begin
        cursor_r <= cursor_nxt;
        mode_r   <= mode_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/cle_serial.sv
`default_nettype none

module cle_serial
  import cle_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire burst_t burst,
  output logic        room,
  output logic        out_valid,
  input  wire logic   out_ready,
  output result_t     out_res,
  output logic        out_last
);

  logic       valid_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  result_t [MaxBeats-1:0] res_r;
  logic       beat_done;

  assign out_valid = valid_r;
  assign out_last  = (idx_r == cnt_r - 2'd1);
  assign out_res   = res_r[idx_r];
  assign beat_done = valid_r & out_ready;
  // free when empty, or once the final beat of the held burst leaves
  assign room      = !valid_r || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 2'd0;
      idx_r   <= 2'd0;
    end else begin
      if (beat_done) begin
        idx_r <= idx_r + 2'd1;
        if (out_last) begin
          valid_r <= 1'b0;
        end
      end
      if (load) begin
        valid_r <= 1'b1;
        cnt_r   <= burst.cnt;
        idx_r   <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= burst.res;
    end
  end

endmodule

`default_nettype wire

>>> hdl/console_line_editor.sv
// Console line editor: one received terminal byte per input beat.
// Input channel in_*: in_tdata[7:0] is the received byte.
// Result channel out_*: one beat per echo/store action, line completion or
// abort; out_tuser is the kind, out_tlast marks the final beat of a byte.
// Configuration channel cfg_*: cfg_data is the maximum line length; it is
// always ready and a write takes effect on the next cycle.
// A byte's first result beat appears in the cycle after its acceptance.
// Throughput: one byte per cycle while out_tready is high; a byte with two or
// three result beats holds in_tready low until its last beat is about to
// leave, so the single result register, one beat per cycle, sets the rate.
// Bytes with no result (escape sequences, backspace at column 0) load no beat.
// Reset: cursor 0, escape tracking normal, maximum length 127, no beat held.
// Stall: a stalled result beat holds its value; in_tready falls until the
// held burst's final beat is taken.
`default_nettype none

module console_line_editor
  import cle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [0] echo_valid, [8:1] echo_byte,
                                       // [9] store_valid, [17:10] store_index,
                                       // [25:18] line_length, [31:26] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  burst_t  burst;
  result_t res;
  logic    room;
  logic    take;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign take      = in_tvalid & room;

  cle_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .take     (take),
    .rx_byte  (in_tdata),
    .burst    (burst)
  );

  cle_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && burst.cnt != 2'd0),
    .burst     (burst),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {6'd0, res.line_length, res.store_index, res.store_valid,
                      res.echo_byte, res.echo_valid};

endmodule

`default_nettype wire

>>> hdl/cle_checker.sv
`default_nettype none

module cle_checker
  import cle_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // completion and abort end the burst of their byte
  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE || out_tuser == KIND_ABORT) |-> out_tlast)
    else $error("line control beat not last");

  a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ECHO |-> out_tdata[17:0] == 18'd0)
    else $error("echo or store fields set on line control beat");

  // a taken non-final beat is followed by a valid echo/store or completion beat
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tuser == KIND_ECHO || out_tuser == KIND_DONE))
    else $error("burst broken after non-final beat");

endmodule

bind console_line_editor cle_checker u_cle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cle_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumSegs    = 9;

  typedef struct packed {
    logic [1:0] kind;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] line_length;
    logic       last;
  } beat_t;

  // one directed stimulus row; typed rows carry their own expected beats
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    int         n;
    beat_t      exp [3];
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [0] echo_valid, [8:1] echo_byte, [9] store_valid,
                                  // [17:10] store_index, [25:18] line_length
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // predictor state
  logic [7:0] line_cursor;
  logic [1:0] esc_state;
  logic [7:0] line_limit;

  beat_t    byte_beats[$];
  beat_t    pending_beats[$];
  dir_row_t dir_rows[$];

  int in_gap_pct  = 0;
  int out_gap_pct = 0;
  int err_cnt     = 0;
  int bytes_sent  = 0;
  int beats_seen  = 0;
  int cfg_writes  = 0;
  int cycle_cnt   = 0;

  int seg_limit  [NumSegs] = '{1, 0, 255, 200, 10, 127, 3, 64, 255};
  int seg_items  [NumSegs] = '{15, 10, 260, 30, 15, 15, 12, 15, 10};
  bit seg_plain  [NumSegs] = '{0, 0, 1, 1, 0, 0, 0, 0, 0};
  int seg_in_gap [NumSegs] = '{7, 7, 7, 57, 57, 57, 0, 0, 0};
  int seg_out_gap[NumSegs] = '{57, 57, 57, 7, 7, 7, 0, 0, 0};

  console_line_editor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic beat_t mk_beat(logic [1:0] kind, logic ev, logic [7:0] ec, logic sv,
                                    logic [7:0] si, logic [7:0] len, logic lst);
    beat_t b;
    b.kind        = kind;
    b.echo_valid  = ev;
    b.echo_byte   = ec;
    b.store_valid = sv;
    b.store_index = si;
    b.line_length = len;
    b.last        = lst;
    return b;
  endfunction

  function automatic string beat_str(beat_t b);
    return $sformatf("kind=%0d echo=%0d/%02h store=%0d/%0d len=%0d last=%0d", b.kind,
                     b.echo_valid, b.echo_byte, b.store_valid, b.store_index,
                     b.line_length, b.last);
  endfunction

  // compute the beats caused by one received byte and advance the editor state
  function automatic void predict_byte(logic [7:0] rx);
    logic [7:0] lim;
    byte_beats.delete();
    if (esc_state == MODE_ESC) begin
      esc_state = (rx == CH_LBRK) ? MODE_CSI : MODE_NORMAL;
      return;
    end
    if (esc_state == MODE_CSI) begin
      if (rx >= CSI_LO && rx <= CSI_HI) esc_state = MODE_NORMAL;
      return;
    end
    case (rx)
      CH_ETX, CH_EOT: begin
        byte_beats.push_back(mk_beat(KIND_ABORT, 0, 0, 0, 0, 0, 0));
        line_cursor = '0;
      end
      CH_BS: begin
        if (line_cursor != 0) begin
          line_cursor = line_cursor - 8'd1;
          byte_beats.push_back(mk_beat(KIND_ECHO, 1, CH_BS, 0, 0, 0, 0));
        end
      end
      CH_LF: byte_beats.push_back(mk_beat(KIND_ECHO, 1, CH_LF, 0, 0, 0, 0));
      CH_CR: begin
        byte_beats.push_back(mk_beat(KIND_ECHO, 1, CH_LF, 0, 0, 0, 0));
        byte_beats.push_back(mk_beat(KIND_ECHO, 1, CH_CR, 0, 0, 0, 0));
        byte_beats.push_back(mk_beat(KIND_DONE, 0, 0, 0, 0, line_cursor, 0));
        line_cursor = '0;
      end
      CH_ESC: esc_state = MODE_ESC;
      default: begin
        lim = (line_limit == 0) ? 8'd1 : line_limit;
        byte_beats.push_back(mk_beat(KIND_ECHO, rx != 0, rx, 1, line_cursor, 0, 0));
        if (line_cursor != 8'hff) line_cursor = line_cursor + 8'd1;
        if (line_cursor >= lim) begin
          byte_beats.push_back(mk_beat(KIND_DONE, 0, 0, 0, 0, line_cursor, 0));
          line_cursor = '0;
        end
      end
    endcase
    if (byte_beats.size() > 0) byte_beats[byte_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("%0t: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic add_row(input logic [7:0] rx, input bit typed = 1'b0, input int n = 0,
                         input beat_t e0 = '0, input beat_t e1 = '0, input beat_t e2 = '0);
    dir_row_t r;
    r.rx     = rx;
    r.typed  = typed;
    r.n      = n;
    r.exp[0] = e0;
    r.exp[1] = e1;
    r.exp[2] = e2;
    dir_rows.push_back(r);
  endtask

  // present one byte, hold it until taken, then run the predictor on it
  task automatic accept_byte(input logic [7:0] rx);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    predict_byte(rx);
  endtask

  task automatic send_byte(input logic [7:0] rx);
    accept_byte(rx);
    foreach (byte_beats[i]) pending_beats.push_back(byte_beats[i]);
  endtask

  // drop valid and wait until every predicted beat has left the block
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    line_limit = v;
    cfg_writes++;
  endtask

  task automatic send_escape(input bit broken);
    logic [7:0] v;
    int k;
    send_byte(CH_ESC);
    if (broken) begin
      if ($urandom_range(1) == 1) send_byte(CH_LBRK);
      k = $urandom_range(3);
      repeat (k) send_byte(8'($urandom_range(255)));
    end else if ($urandom_range(2) == 0) begin
      do v = 8'($urandom_range(255)); while (v == CH_LBRK);
      send_byte(v);
    end else begin
      send_byte(CH_LBRK);
      k = $urandom_range(3);
      repeat (k) send_byte(8'($urandom_range(8'h30, 8'h3f)));
      send_byte(8'($urandom_range(CSI_LO, CSI_HI)));
    end
  endtask

  // escape sequences are extra traffic and do not count toward n
  task automatic send_mixed(input int n);
    int done_cnt;
    int pick;
    done_cnt = 0;
    while (done_cnt < n) begin
      pick = $urandom_range(99);
      if (pick >= 72 && pick < 88) begin
        send_escape(pick >= 84);
      end else begin
        if (pick < 45) send_byte(8'($urandom_range(8'h20, 8'h7e)));
        else if (pick < 55) send_byte(8'($urandom_range(255)));
        else if (pick < 61) send_byte(CH_BS);
        else if (pick < 66) send_byte(CH_CR);
        else if (pick < 69) send_byte(CH_LF);
        else if (pick < 72) send_byte($urandom_range(1) ? CH_ETX : CH_EOT);
        else if (pick < 97) send_byte(8'($urandom_range(8'h80, 8'hff)));
        else send_byte(8'h00);
        done_cnt++;
      end
    end
  endtask

  // result side: check each beat taken, then pick the next ready level
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = mk_beat(out_tuser, out_tdata[0], out_tdata[8:1], out_tdata[9],
                      out_tdata[17:10], out_tdata[25:18], out_tlast);
        beats_seen++;
        if (pending_beats.size() == 0) begin
          note_error($sformatf("unexpected beat: %s", beat_str(got)));
        end else begin
          want = pending_beats.pop_front();
          if (got !== want)
            note_error($sformatf("expected %s, got %s", beat_str(want), beat_str(got)));
        end
      end
      out_tready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               pending_beats.size());
      $display("[console_line_editor] ERROR");
      $finish;
    end
  end

  initial begin
    line_cursor = '0;
    esc_state   = MODE_NORMAL;
    line_limit  = MaxLenReset;

    add_row(CH_BS, 1, 0);
    add_row(8'h00, 1, 1, mk_beat(KIND_ECHO, 0, 8'h00, 1, 8'd0, 0, 1));
    add_row(8'hff, 1, 1, mk_beat(KIND_ECHO, 1, 8'hff, 1, 8'd1, 0, 1));
    add_row(8'h41);
    add_row(CH_BS, 1, 1, mk_beat(KIND_ECHO, 1, CH_BS, 0, 0, 0, 1));
    add_row(CH_LF, 1, 1, mk_beat(KIND_ECHO, 1, CH_LF, 0, 0, 0, 1));
    add_row(CH_CR, 1, 3, mk_beat(KIND_ECHO, 1, CH_LF, 0, 0, 0, 0),
            mk_beat(KIND_ECHO, 1, CH_CR, 0, 0, 0, 0),
            mk_beat(KIND_DONE, 0, 0, 0, 0, 8'd2, 1));
    add_row(CH_ETX, 1, 1, mk_beat(KIND_ABORT, 0, 0, 0, 0, 0, 1));
    add_row(8'h78);
    add_row(CH_EOT, 1, 1, mk_beat(KIND_ABORT, 0, 0, 0, 0, 0, 1));
    // plain escape, then a CSI with parameters and near-miss final bytes
    add_row(CH_ESC, 1, 0);
    add_row(8'h5a, 1, 0);
    add_row(CH_ESC, 1, 0);
    add_row(CH_LBRK, 1, 0);
    add_row(8'h31, 1, 0);
    add_row(8'h3b, 1, 0);
    add_row(8'h3f, 1, 0);
    add_row(8'h7f, 1, 0);
    add_row(CSI_LO, 1, 0);
    add_row(CH_ESC, 1, 0);
    add_row(CH_LBRK, 1, 0);
    add_row(CSI_HI, 1, 0);
    // ESC right after ESC is swallowed as the escaped byte
    add_row(CH_ESC, 1, 0);
    add_row(CH_ESC, 1, 0);
    add_row(8'h71);
    add_row(CH_CR);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_pct  = 7;
    out_gap_pct = 57;
    foreach (dir_rows[i]) begin
      accept_byte(dir_rows[i].rx);
      if (dir_rows[i].typed) begin
        for (int j = 0; j < dir_rows[i].n; j++) pending_beats.push_back(dir_rows[i].exp[j]);
      end else begin
        foreach (byte_beats[j]) pending_beats.push_back(byte_beats[j]);
      end
    end

    for (int s = 0; s < NumSegs; s++) begin
      in_gap_pct  = seg_in_gap[s];
      out_gap_pct = seg_out_gap[s];
      write_limit(8'(seg_limit[s]));
      if (seg_plain[s]) begin
        repeat (seg_items[s])
          send_byte($urandom_range(3) == 0 ? 8'($urandom_range(8'h80, 8'hff))
                                           : 8'($urandom_range(8'h20, 8'h7e)));
      end else begin
        send_mixed(seg_items[s]);
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes (%0d directed) and %0d result beats in %0d cycles.",
             bytes_sent, dir_rows.size(), beats_seen, cycle_cnt);
    $display("Line limit written %0d times, from 0 and 1 up to 255; %0d mismatches.",
             cfg_writes, err_cnt);
    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("[console_line_editor] OK");
    end else begin
      $display("[console_line_editor] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cle_pkg.sv
hdl/cle_decode.sv
hdl/cle_serial.sv
hdl/console_line_editor.sv
hdl/cle_checker.sv
bench/tb_top.sv
